>>> design/u16u8_pkg.sv
// Shared types and constants for the UTF-16 to UTF-8 transcoder.
// No dependencies.
package u16u8_pkg;

   typedef logic [7:0]  byte_type;
   typedef logic [15:0] unit_type;
   typedef logic [20:0] code_point_type;

   typedef enum logic [1:0] {
      STATUS_DATA     = 2'd0,
      STATUS_BAD_PAIR = 2'd1,
      STATUS_LONE_LOW = 2'd2
   } status_type;

   // Byte position inside the UTF-16 stream.
   typedef enum logic [1:0] {
      PH_LEAD_FIRST = 2'd0,
      PH_LEAD_SECOND = 2'd1,
      PH_PAIR_FIRST = 2'd2,
      PH_PAIR_SECOND = 2'd3
   } phase_type;

   localparam unit_type SURR_HIGH_BASE = 16'hd800;
   localparam unit_type SURR_LOW_BASE  = 16'hdc00;
   localparam unit_type SURR_END       = 16'he000;
   localparam code_point_type SUPP_BASE = 21'h10000;
   localparam byte_type BOM_FF = 8'hff;
   localparam byte_type BOM_FE = 8'hfe;

   // One group of UTF-8 bytes; last_idx is the index of the final byte.
   typedef struct packed {
      logic [3:0][7:0] data;
      logic [1:0]      last_idx;
      status_type      status;
   } bundle_type;

endpackage

>>> design/u16u8_encoder.sv
// UTF-8 encoder: one code point into 1 to 4 bytes.
// Depends on u16u8_pkg.
module u16u8_encoder (
   input  u16u8_pkg::code_point_type code_point,
   output u16u8_pkg::bundle_type     bundle
);
   import u16u8_pkg::*;

   always_comb begin
      bundle = '0;
      bundle.status = STATUS_DATA;
      priority if (code_point <= 21'h7f) begin
         bundle.data[0] = {1'b0, code_point[6:0]};
         bundle.last_idx = 2'd0;
      end else if (code_point <= 21'h7ff) begin
         bundle.data[0] = {3'b110, code_point[10:6]};
         bundle.data[1] = {2'b10, code_point[5:0]};
         bundle.last_idx = 2'd1;
      end else if (code_point <= 21'hffff) begin
         bundle.data[0] = {4'b1110, code_point[15:12]};
         bundle.data[1] = {2'b10, code_point[11:6]};
         bundle.data[2] = {2'b10, code_point[5:0]};
         bundle.last_idx = 2'd2;
      end else begin
         bundle.data[0] = {5'b11110, code_point[20:18]};
         bundle.data[1] = {2'b10, code_point[17:12]};
         bundle.data[2] = {2'b10, code_point[11:6]};
         bundle.data[3] = {2'b10, code_point[5:0]};
         bundle.last_idx = 2'd3;
      end
   end

endmodule

>>> design/utf16_to_utf8_transcoder.sv
// UTF-16 byte stream to UTF-8 byte stream transcoder, top level.
// Depends on u16u8_pkg and u16u8_encoder.
//
// Channel  Dir  Handshake                Payload
// req      in   req_valid / req_ready    req_in_byte[7:0]
// rsp      out  rsp_valid / rsp_ready    rsp_out_byte[7:0], rsp_last, rsp_status[1:0]
// csr      in   csr_wr_en (no wait)      csr_wr_data (initial byte order)
//
// A completed code unit is decoded and encoded in the cycle it is accepted and lands
// in the result bundle register; bytes then leave one per cycle while rsp_ready is high.
// A unit takes 2 input transfers; each character's 1 to 4 output bytes set the pace, and
// the result is offered on rsp from the cycle after the accepting transfer.
// First bytes of a unit, and every byte after a halt, are taken even while rsp stalls.
// A second byte waits only until the last byte of the pending bundle is transferred.
// Synchronous active-high reset clears all control state; no clearing pass.
module utf16_to_utf8_transcoder (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  u16u8_pkg::byte_type   req_in_byte,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output u16u8_pkg::byte_type   rsp_out_byte,
   output logic                  rsp_last,
   output u16u8_pkg::status_type rsp_status,
   input  logic                  csr_wr_en,
   input  logic                  csr_wr_data
);
   import u16u8_pkg::*;

   // Stream state
   phase_type  phase_ff, phase_in;
   byte_type   held_ff, held_in;
   logic [9:0] high_ff, high_in;
   logic       order_ff, order_in;
   logic       init_order_ff, init_order_in;
   logic       started_ff, started_in;
   logic       halted_ff, halted_in;

   // Result bundle and byte pointer
   bundle_type bundle_ff, bundle_in;
   logic       valid_ff, valid_in;
   logic [1:0] idx_ff, idx_in;

   logic           accept;
   logic           rsp_take;
   logic           bundle_free;
   logic           may_produce;
   unit_type       unit_val;
   logic           is_high, is_low, is_bom_le, is_bom_be;
   code_point_type code_point;
   bundle_type     enc_bundle;
   bundle_type     new_bundle;
   logic           load;

   // Assemble the 16-bit unit in the current order (first byte is high in big endian)
   assign unit_val = order_ff ? {req_in_byte, held_ff} : {held_ff, req_in_byte};
   assign is_high = (unit_val >= SURR_HIGH_BASE) && (unit_val < SURR_LOW_BASE);
   assign is_low  = (unit_val >= SURR_LOW_BASE) && (unit_val < SURR_END);
   assign is_bom_le = !started_ff && (held_ff == BOM_FF) && (req_in_byte == BOM_FE);
   assign is_bom_be = !started_ff && (held_ff == BOM_FE) && (req_in_byte == BOM_FF);

   // Supplementary code point: {high10, low10} + 0x10000; otherwise the unit itself
   assign code_point = (phase_ff == PH_PAIR_SECOND)
                       ? ({1'b0, high_ff, unit_val[9:0]} + SUPP_BASE)
                       : {5'd0, unit_val};

   u16u8_encoder u_encoder (
      .code_point (code_point),
      .bundle     (enc_bundle)
   );

   // Output side
   assign rsp_valid    = valid_ff;
   assign rsp_out_byte = bundle_ff.data[idx_ff];
   assign rsp_last     = (idx_ff == bundle_ff.last_idx);
   assign rsp_status   = bundle_ff.status;
   assign rsp_take     = valid_ff && rsp_ready;

   // Bundle register frees up when its final byte is transferred
   assign bundle_free = !valid_ff || (rsp_take && rsp_last);
   assign may_produce = !halted_ff && phase_ff[0];
   assign req_ready   = bundle_free || !may_produce;
   assign accept      = req_valid && req_ready;

   // Next-state logic for the byte phase
   always_comb begin
      phase_in = phase_ff;
      if (accept && !halted_ff) begin
         unique case (phase_ff)
            PH_LEAD_FIRST:  phase_in = PH_LEAD_SECOND;
            PH_PAIR_FIRST:  phase_in = PH_PAIR_SECOND;
            PH_LEAD_SECOND: phase_in = (!is_bom_le && !is_bom_be && is_high)
                                       ? PH_PAIR_FIRST : PH_LEAD_FIRST;
            PH_PAIR_SECOND: phase_in = PH_LEAD_FIRST;
            default:        phase_in = PH_LEAD_FIRST;
         endcase
      end
   end

   // Per-item outputs: held bytes, order, flags and the new bundle
   always_comb begin
      held_in    = held_ff;
      high_in    = high_ff;
      order_in   = order_ff;
      started_in = started_ff;
      halted_in  = halted_ff;
      load       = 1'b0;
      new_bundle = enc_bundle;
      init_order_in = csr_wr_en ? csr_wr_data : init_order_ff;
      if (csr_wr_en && !started_ff) begin
         order_in = csr_wr_data;
      end
      if (accept && !halted_ff) begin
         unique case (phase_ff)
            PH_LEAD_FIRST, PH_PAIR_FIRST: begin
               held_in = req_in_byte;
            end
            PH_PAIR_SECOND: begin
               load = 1'b1;
               started_in = 1'b1;
               if (!is_low) begin
                  new_bundle = '0;
                  new_bundle.status = STATUS_BAD_PAIR;
               end
            end
            PH_LEAD_SECOND: begin
               priority if (is_bom_le) begin
                  order_in = 1'b1;
               end else if (is_bom_be) begin
                  order_in = 1'b0;
               end else if (is_high) begin
                  high_in = unit_val[9:0];
               end else if (is_low) begin
                  load = 1'b1;
                  started_in = 1'b1;
                  halted_in = 1'b1;
                  new_bundle = '0;
                  new_bundle.status = STATUS_LONE_LOW;
               end else begin
                  load = 1'b1;
                  started_in = 1'b1;
               end
            end
            default: begin
               held_in = held_ff;
            end
         endcase
      end
   end

   // Bundle register control
   always_comb begin
      bundle_in = bundle_ff;
      valid_in  = valid_ff;
      idx_in    = idx_ff;
      if (load) begin
         bundle_in = new_bundle;
         valid_in  = 1'b1;
         idx_in    = 2'd0;
      end else if (rsp_take) begin
         if (rsp_last) begin
            valid_in = 1'b0;
         end else begin
            idx_in = idx_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_LEAD_FIRST;
         held_ff       <= '0;
         high_ff       <= '0;
         order_ff      <= 1'b0;
         init_order_ff <= 1'b0;
         started_ff    <= 1'b0;
         halted_ff     <= 1'b0;
         valid_ff      <= 1'b0;
         idx_ff        <= 2'd0;
      end else begin
         phase_ff      <= phase_in;
         held_ff       <= held_in;
         high_ff       <= high_in;
         order_ff      <= order_in;
         init_order_ff <= init_order_in;
         started_ff    <= started_in;
         halted_ff     <= halted_in;
         valid_ff      <= valid_in;
         idx_ff        <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      bundle_ff <= bundle_in;
   end

   // A halt lasts until reset
   a_halt_sticky: assert property (@(posedge clock) disable iff (reset)
      halted_ff |=> halted_ff)
      else $error("halt flag cleared without reset");

   // Nothing new enters the bundle once halted
   a_no_load_halted: assert property (@(posedge clock) disable iff (reset)
      halted_ff |-> !load)
      else $error("bundle loaded while halted");

   // A bundle never overwrites bytes still pending
   a_load_free: assert property (@(posedge clock) disable iff (reset)
      load |-> bundle_free)
      else $error("bundle overwritten before final byte transferred");

   // Byte pointer stays within the bundle
   a_idx_range: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> (idx_ff <= bundle_ff.last_idx))
      else $error("byte pointer beyond bundle");

   // A lone-low error result always comes with the halt flag
   a_lone_low_halts: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && (bundle_ff.status == STATUS_LONE_LOW)) |-> halted_ff)
      else $error("lone low surrogate reported without halt");

endmodule
